// ----- rtl/core/dag_task_completion_times_assert.svh -----
// Assertion macros for the task completion time block
`ifndef DAG_TASK_COMPLETION_TIMES_ASSERT_SVH
`define DAG_TASK_COMPLETION_TIMES_ASSERT_SVH

// Check a property on every clock edge outside reset
`define DTCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle
`define DTCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/dtct_pkg.sv -----
package dtct_pkg;

  localparam int unsigned TIME_W = 22;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned VC_W   = 7;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SETD  = 2'd1;
  localparam logic [1:0] OP_ADDE  = 2'd2;
  localparam logic [1:0] OP_RUN   = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADDE,
    S_ZERO,
    S_CNT_HEAD,
    S_HEADW,
    S_EDGEW,
    S_TBLW,
    S_SEED_RD,
    S_SEED_W,
    S_KAHN_CHK,
    S_KAHN_V,
    S_FINI_RD,
    S_FINI_W,
    S_CRIT_RD,
    S_CRIT_V,
    S_EMIT_RD,
    S_EMIT_V,
    S_EMIT_F,
    S_OUT_W
  } state_e;

  typedef enum logic [1:0] {
    PH_CNT,
    PH_KAHN,
    PH_CRIT
  } phase_e;

endpackage

// ----- rtl/core/dtct_ram.sv -----
module dtct_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dag_task_completion_times.sv -----
// Clear and set-duration commands are taken in the idle state; add-edge also writes in S_ADDE,
// and a run steps through the count, seed, Kahn, finish and critical-path phases, then emits.
// Each table is a RAM with a registered read; the run walks the stored edge lists serially.
// One command at a time; results of a run come one by one, each held until it is taken.
// Reset: asynchronous, active low; clears edge lists, durations, edge count, drop flag,
// and sets the task count to MAX_VERTICES. Tables need no clearing pass.
`include "dag_task_completion_times_assert.svh"

module dag_task_completion_times #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  first_vertex_i,
  input  logic [5:0]  second_vertex_i,
  input  logic [15:0] task_duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  vertex_id_o,
  output logic [21:0] finish_time_o,
  output logic        cycle_found_o,
  output logic        edges_dropped_o,
  output logic        last_item_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned LW = $clog2(MAX_EDGES + 1);
  localparam int unsigned TW = dtct_pkg::TIME_W;
  localparam int unsigned DW = dtct_pkg::DUR_W;
  localparam int unsigned XW = dtct_pkg::VC_W;
  localparam logic [LW-1:0] Empty = LW'(MAX_EDGES);

  dtct_pkg::state_e state_q, state_d;
  dtct_pkg::phase_e phase_q, phase_d;

  logic [XW-1:0]           vc_q, vc_d;
  logic [MAX_VERTICES-1:0] head_vld_q, head_vld_d;
  logic [MAX_VERTICES-1:0] dur_vld_q, dur_vld_d;
  logic [LW-1:0]           total_q, total_d;
  logic                    drop_q, drop_d;
  logic [VW-1:0]           a_q, a_d, b_q, b_d, w_q, w_d;
  logic [CW-1:0]           idx_q, idx_d, front_q, front_d, rear_q, rear_d;
  logic [LW-1:0]           link_q, link_d;
  logic [TW-1:0]           fv_q, fv_d;
  logic                    hv_q, dv_q;
  logic                    out_valid_q, out_valid_d;
  logic [VW-1:0]           out_vid_q, out_vid_d;
  logic [TW-1:0]           out_time_q, out_time_d;
  logic                    out_cyc_q, out_cyc_d, out_last_q, out_last_d;

  logic [CW-1:0] n;
  logic [CW-1:0] idx_inc;

  logic          head_we;
  logic [VW-1:0] head_waddr, head_raddr;
  logic [LW-1:0] head_wdata, head_rdata;

  logic             edge_we;
  logic [EW-1:0]    edge_waddr, edge_raddr;
  logic [VW+LW-1:0] edge_wdata, edge_rdata;

  logic          dur_we;
  logic [VW-1:0] dur_waddr, dur_raddr;
  logic [DW-1:0] dur_wdata, dur_rdata;

  logic          ind_we;
  logic [VW-1:0] ind_waddr, ind_raddr;
  logic [LW-1:0] ind_wdata, ind_rdata;

  logic          fifo_we;
  logic [VW-1:0] fifo_waddr, fifo_raddr;
  logic [VW-1:0] fifo_wdata, fifo_rdata;

  logic          fin_we;
  logic [VW-1:0] fin_waddr, fin_raddr;
  logic [TW-1:0] fin_wdata, fin_rdata;

  logic          adv;
  logic [LW-1:0] adv_link;
  logic [VW-1:0] e_tgt;
  logic [LW-1:0] e_lnk;
  logic [LW-1:0] ind_dec;
  logic [TW-1:0] cand;

  always_comb begin
    if (vc_q == '0) begin
      n = CW'(1);
    end else if (vc_q > XW'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = vc_q[CW-1:0];
    end
  end

  assign idx_inc = idx_q + CW'(1);
  assign {e_tgt, e_lnk} = edge_rdata;
  assign ind_dec = (ind_rdata != '0) ? (ind_rdata - LW'(1)) : '0;
  assign cand = fv_q + (dv_q ? TW'(dur_rdata) : '0);

  dtct_ram #(.Depth(MAX_VERTICES), .Width(LW)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  dtct_ram #(.Depth(MAX_EDGES), .Width(VW + LW)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  dtct_ram #(.Depth(MAX_VERTICES), .Width(DW)) u_dur (
    .clk_i, .we_i(dur_we), .waddr_i(dur_waddr), .wdata_i(dur_wdata),
    .raddr_i(dur_raddr), .rdata_o(dur_rdata)
  );
  dtct_ram #(.Depth(MAX_VERTICES), .Width(LW)) u_indeg (
    .clk_i, .we_i(ind_we), .waddr_i(ind_waddr), .wdata_i(ind_wdata),
    .raddr_i(ind_raddr), .rdata_o(ind_rdata)
  );
  dtct_ram #(.Depth(MAX_VERTICES), .Width(VW)) u_fifo (
    .clk_i, .we_i(fifo_we), .waddr_i(fifo_waddr), .wdata_i(fifo_wdata),
    .raddr_i(fifo_raddr), .rdata_o(fifo_rdata)
  );
  dtct_ram #(.Depth(MAX_VERTICES), .Width(TW)) u_fin (
    .clk_i, .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(fin_wdata),
    .raddr_i(fin_raddr), .rdata_o(fin_rdata)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    vc_d        = cfg_we_i ? cfg_wdata_i : vc_q;
    head_vld_d  = head_vld_q;
    dur_vld_d   = dur_vld_q;
    total_d     = total_q;
    drop_d      = drop_q;
    a_d         = a_q;
    b_d         = b_q;
    w_d         = w_q;
    idx_d       = idx_q;
    front_d     = front_q;
    rear_d      = rear_q;
    link_d      = link_q;
    fv_d        = fv_q;
    out_valid_d = out_valid_q;
    out_vid_d   = out_vid_q;
    out_time_d  = out_time_q;
    out_cyc_d   = out_cyc_q;
    out_last_d  = out_last_q;
    in_ready_o  = 1'b0;
    head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
    edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0; edge_raddr = '0;
    dur_we  = 1'b0; dur_waddr  = '0; dur_wdata  = '0; dur_raddr  = '0;
    ind_we  = 1'b0; ind_waddr  = '0; ind_wdata  = '0; ind_raddr  = '0;
    fifo_we = 1'b0; fifo_waddr = '0; fifo_wdata = '0; fifo_raddr = '0;
    fin_we  = 1'b0; fin_waddr  = '0; fin_wdata  = '0; fin_raddr  = '0;
    adv      = 1'b0;
    adv_link = Empty;

    unique case (state_q)
      dtct_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (opcode_i)
            dtct_pkg::OP_CLEAR: begin
              head_vld_d = '0;
              total_d    = '0;
              drop_d     = 1'b0;
            end
            dtct_pkg::OP_SETD: begin
              if (7'(first_vertex_i) < 7'(MAX_VERTICES)) begin
                dur_we    = 1'b1;
                dur_waddr = first_vertex_i[VW-1:0];
                dur_wdata = task_duration_i;
                dur_vld_d[first_vertex_i[VW-1:0]] = 1'b1;
              end
            end
            dtct_pkg::OP_ADDE: begin
              if (7'(first_vertex_i) >= 7'(n) || 7'(second_vertex_i) >= 7'(n) ||
                  total_q >= Empty) begin
                drop_d = 1'b1;
              end else begin
                a_d        = first_vertex_i[VW-1:0];
                b_d        = second_vertex_i[VW-1:0];
                head_raddr = first_vertex_i[VW-1:0];
                state_d    = dtct_pkg::S_ADDE;
              end
            end
            default: begin
              idx_d   = '0;
              front_d = '0;
              rear_d  = '0;
              state_d = dtct_pkg::S_ZERO;
            end
          endcase
        end
      end
      dtct_pkg::S_ADDE: begin
        edge_we    = 1'b1;
        edge_waddr = total_q[EW-1:0];
        edge_wdata = {b_q, (hv_q ? head_rdata : Empty)};
        head_we    = 1'b1;
        head_waddr = a_q;
        head_wdata = total_q;
        head_vld_d[a_q] = 1'b1;
        total_d    = total_q + LW'(1);
        state_d    = dtct_pkg::S_IDLE;
      end
      dtct_pkg::S_ZERO: begin
        ind_we    = 1'b1;
        ind_waddr = idx_q[VW-1:0];
        if (idx_inc == n) begin
          idx_d   = '0;
          phase_d = dtct_pkg::PH_CNT;
          state_d = dtct_pkg::S_CNT_HEAD;
        end else begin
          idx_d = idx_inc;
        end
      end
      dtct_pkg::S_CNT_HEAD: begin
        head_raddr = idx_q[VW-1:0];
        state_d    = dtct_pkg::S_HEADW;
      end
      dtct_pkg::S_HEADW: begin
        if (phase_q == dtct_pkg::PH_CRIT) begin
          fv_d = fin_rdata;
        end
        adv      = 1'b1;
        adv_link = hv_q ? head_rdata : Empty;
      end
      dtct_pkg::S_EDGEW: begin
        link_d = e_lnk;
        w_d    = e_tgt;
        if (CW'(e_tgt) < n) begin
          ind_raddr = e_tgt;
          fin_raddr = e_tgt;
          dur_raddr = e_tgt;
          state_d   = dtct_pkg::S_TBLW;
        end else begin
          adv      = 1'b1;
          adv_link = e_lnk;
        end
      end
      dtct_pkg::S_TBLW: begin
        adv      = 1'b1;
        adv_link = link_q;
        unique case (phase_q)
          dtct_pkg::PH_CNT: begin
            ind_we    = 1'b1;
            ind_waddr = w_q;
            ind_wdata = ind_rdata + LW'(1);
          end
          dtct_pkg::PH_KAHN: begin
            ind_we    = 1'b1;
            ind_waddr = w_q;
            ind_wdata = ind_dec;
            if (ind_dec == '0 && rear_q < n) begin
              fifo_we    = 1'b1;
              fifo_waddr = rear_q[VW-1:0];
              fifo_wdata = w_q;
              rear_d     = rear_q + CW'(1);
            end
          end
          default: begin
            if (cand > fin_rdata) begin
              fin_we    = 1'b1;
              fin_waddr = w_q;
              fin_wdata = cand;
            end
          end
        endcase
      end
      dtct_pkg::S_SEED_RD: begin
        ind_raddr = idx_q[VW-1:0];
        state_d   = dtct_pkg::S_SEED_W;
      end
      dtct_pkg::S_SEED_W: begin
        if (ind_rdata == '0 && rear_q < n) begin
          fifo_we    = 1'b1;
          fifo_waddr = rear_q[VW-1:0];
          fifo_wdata = idx_q[VW-1:0];
          rear_d     = rear_q + CW'(1);
        end
        if (idx_inc == n) begin
          phase_d = dtct_pkg::PH_KAHN;
          state_d = dtct_pkg::S_KAHN_CHK;
        end else begin
          idx_d   = idx_inc;
          state_d = dtct_pkg::S_SEED_RD;
        end
      end
      dtct_pkg::S_KAHN_CHK: begin
        if (front_q < rear_q) begin
          fifo_raddr = front_q[VW-1:0];
          front_d    = front_q + CW'(1);
          state_d    = dtct_pkg::S_KAHN_V;
        end else if (front_q == n) begin
          idx_d   = '0;
          state_d = dtct_pkg::S_FINI_RD;
        end else begin
          out_valid_d = 1'b1;
          out_vid_d   = '0;
          out_time_d  = '0;
          out_cyc_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = dtct_pkg::S_OUT_W;
        end
      end
      dtct_pkg::S_KAHN_V: begin
        head_raddr = fifo_rdata;
        state_d    = dtct_pkg::S_HEADW;
      end
      dtct_pkg::S_FINI_RD: begin
        dur_raddr = idx_q[VW-1:0];
        state_d   = dtct_pkg::S_FINI_W;
      end
      dtct_pkg::S_FINI_W: begin
        fin_we    = 1'b1;
        fin_waddr = idx_q[VW-1:0];
        fin_wdata = dv_q ? TW'(dur_rdata) : '0;
        if (idx_inc == n) begin
          idx_d   = '0;
          phase_d = dtct_pkg::PH_CRIT;
          state_d = dtct_pkg::S_CRIT_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = dtct_pkg::S_FINI_RD;
        end
      end
      dtct_pkg::S_CRIT_RD: begin
        fifo_raddr = idx_q[VW-1:0];
        state_d    = dtct_pkg::S_CRIT_V;
      end
      dtct_pkg::S_CRIT_V: begin
        head_raddr = fifo_rdata;
        fin_raddr  = fifo_rdata;
        state_d    = dtct_pkg::S_HEADW;
      end
      dtct_pkg::S_EMIT_RD: begin
        fifo_raddr = idx_q[VW-1:0];
        state_d    = dtct_pkg::S_EMIT_V;
      end
      dtct_pkg::S_EMIT_V: begin
        out_vid_d = fifo_rdata;
        fin_raddr = fifo_rdata;
        state_d   = dtct_pkg::S_EMIT_F;
      end
      dtct_pkg::S_EMIT_F: begin
        out_valid_d = 1'b1;
        out_time_d  = fin_rdata;
        out_cyc_d   = 1'b0;
        out_last_d  = (idx_inc == n);
        state_d     = dtct_pkg::S_OUT_W;
      end
      dtct_pkg::S_OUT_W: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = dtct_pkg::S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = dtct_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = dtct_pkg::S_IDLE;
      end
    endcase

    if (adv) begin
      if (adv_link < Empty) begin
        edge_raddr = adv_link[EW-1:0];
        state_d    = dtct_pkg::S_EDGEW;
      end else begin
        unique case (phase_q)
          dtct_pkg::PH_CNT: begin
            if (idx_inc == n) begin
              idx_d   = '0;
              state_d = dtct_pkg::S_SEED_RD;
            end else begin
              idx_d   = idx_inc;
              state_d = dtct_pkg::S_CNT_HEAD;
            end
          end
          dtct_pkg::PH_KAHN: begin
            state_d = dtct_pkg::S_KAHN_CHK;
          end
          default: begin
            if (idx_inc == n) begin
              idx_d   = '0;
              state_d = dtct_pkg::S_EMIT_RD;
            end else begin
              idx_d   = idx_inc;
              state_d = dtct_pkg::S_CRIT_RD;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtct_pkg::S_IDLE;
      phase_q     <= dtct_pkg::PH_CNT;
      vc_q        <= XW'(MAX_VERTICES);
      head_vld_q  <= '0;
      dur_vld_q   <= '0;
      total_q     <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      front_q     <= '0;
      rear_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      vc_q        <= vc_d;
      head_vld_q  <= head_vld_d;
      dur_vld_q   <= dur_vld_d;
      total_q     <= total_d;
      drop_q      <= drop_d;
      idx_q       <= idx_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    w_q        <= w_d;
    link_q     <= link_d;
    fv_q       <= fv_d;
    hv_q       <= head_vld_q[head_raddr];
    dv_q       <= dur_vld_q[dur_raddr];
    out_vid_q  <= out_vid_d;
    out_time_q <= out_time_d;
    out_cyc_q  <= out_cyc_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_id_o     = 6'(out_vid_q);
  assign finish_time_o   = out_time_q;
  assign cycle_found_o   = out_cyc_q;
  assign edges_dropped_o = drop_q;
  assign last_item_o     = out_last_q;

  `DTCT_ASSERT(a_ready_no_result, in_ready_o |-> !out_valid_o, "item taken while result pending")
  `DTCT_ASSERT(a_fifo_order, front_q <= rear_q, "ready queue read past its tail")
  `DTCT_ASSERT(a_cycle_last, (out_valid_o && cycle_found_o) |-> last_item_o, "cycle not last")
  `DTCT_ASSERT_NEXT(a_total_step, state_q == dtct_pkg::S_ADDE, total_q == $past(total_q) + 1'b1, "edge count not advanced")

endmodule

// ----- test/dag_task_completion_times_test.sv -----
module dag_task_completion_times_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] dur;
  } cmd_t;

  typedef struct {
    logic [5:0]  vid;
    logic [21:0] ftime;
    logic        cyc;
    logic        drop;
    logic        last;
  } order_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [5:0]  first_vertex_i;
  logic [5:0]  second_vertex_i;
  logic [15:0] task_duration_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [5:0]  vertex_id_o;
  logic [21:0] finish_time_o;
  logic        cycle_found_o;
  logic        edges_dropped_o;
  logic        last_item_o;

  dag_task_completion_times dut (.*);

  cmd_t   pending_cmds[$];
  order_t due_orders[$];

  // Mirror of the block's state
  int unsigned dur_tbl[NV];
  int unsigned head_tbl[NV];
  int unsigned tgt_tbl[NE];
  int unsigned link_tbl[NE];
  int unsigned edge_cnt;
  bit          drop_seen;
  int unsigned task_cnt;

  int  errors, cmds_sent, orders_seen, runs_done, cycles_seen;
  bit  idle_on;
  bit  hold_req;
  int  src_gap, sink_gap, long_hold, quiet;

  function automatic int unsigned live_tasks();
    if (task_cnt < 1) return 1;
    if (task_cnt > NV) return NV;
    return task_cnt;
  endfunction

  function automatic void sort_tasks();
    int unsigned n, indeg[NV], fifo[NV], fin[NV];
    int unsigned front, rear, done, v, e, w, cand;
    order_t r;
    n = live_tasks();
    front = 0;
    rear = 0;
    done = 0;
    for (int i = 0; i < n; i++) indeg[i] = 0;
    for (v = 0; v < n; v++)
      for (e = head_tbl[v]; e < NE; e = link_tbl[e])
        if (tgt_tbl[e] < n) indeg[tgt_tbl[e]]++;
    for (v = 0; v < n; v++)
      if (indeg[v] == 0) fifo[rear++] = v;
    while (front < rear) begin
      v = fifo[front++];
      done++;
      for (e = head_tbl[v]; e < NE; e = link_tbl[e]) begin
        w = tgt_tbl[e];
        if (w < n) begin
          if (indeg[w] > 0) indeg[w]--;
          if (indeg[w] == 0 && rear < n) fifo[rear++] = w;
        end
      end
    end
    runs_done++;
    if (done != n) begin
      cycles_seen++;
      r = '{vid: '0, ftime: '0, cyc: 1'b1, drop: drop_seen, last: 1'b1};
      due_orders.push_back(r);
      return;
    end
    for (v = 0; v < n; v++) fin[v] = dur_tbl[v];
    for (int i = 0; i < n; i++) begin
      v = fifo[i];
      for (e = head_tbl[v]; e < NE; e = link_tbl[e]) begin
        w = tgt_tbl[e];
        if (w < n) begin
          cand = fin[v] + dur_tbl[w];
          if (cand > fin[w]) fin[w] = cand;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r = '{vid: 6'(fifo[i]), ftime: 22'(fin[fifo[i]]), cyc: 1'b0, drop: drop_seen,
            last: (i + 1 == n)};
      due_orders.push_back(r);
    end
  endfunction

  function automatic void predict_cmd(cmd_t c);
    int unsigned n;
    n = live_tasks();
    case (c.op)
      dtct_pkg::OP_CLEAR: begin
        foreach (head_tbl[i]) head_tbl[i] = NE;
        edge_cnt = 0;
        drop_seen = 0;
      end
      dtct_pkg::OP_SETD: dur_tbl[c.src] = c.dur;
      dtct_pkg::OP_ADDE: begin
        if (c.src >= n || c.dst >= n || edge_cnt >= NE) begin
          drop_seen = 1;
        end else begin
          tgt_tbl[edge_cnt] = c.dst;
          link_tbl[edge_cnt] = head_tbl[c.src];
          head_tbl[c.src] = edge_cnt;
          edge_cnt++;
        end
      end
      default: sort_tasks();
    endcase
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      opcode_i <= dtct_pkg::OP_CLEAR;
      first_vertex_i <= 0;
      second_vertex_i <= 0;
      task_duration_i <= 0;
      src_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_cmd('{op: opcode_i, src: first_vertex_i, dst: second_vertex_i,
                      dur: task_duration_i});
        cmds_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 0;
        end else if (pending_cmds.size() > 0) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_valid_i <= 1;
          opcode_i <= c.op;
          first_vertex_i <= c.src;
          second_vertex_i <= c.dst;
          task_duration_i <= c.dur;
          if (idle_on && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
      sink_gap = 0;
      long_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        orders_seen++;
        if (due_orders.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: vid=%0d time=%0d cyc=%0b drop=%0b last=%0b",
                     vertex_id_o, finish_time_o, cycle_found_o, edges_dropped_o,
                     last_item_o);
        end else begin
          order_t x;
          x = due_orders.pop_front();
          if (x.vid !== vertex_id_o || x.ftime !== finish_time_o ||
              x.cyc !== cycle_found_o || x.drop !== edges_dropped_o ||
              x.last !== last_item_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp vid=%0d time=%0d cyc=%0b drop=%0b last=%0b, %s%0d %0d %0b %0b %0b",
                       x.vid, x.ftime, x.cyc, x.drop, x.last, "got ",
                       vertex_id_o, finish_time_o, cycle_found_o, edges_dropped_o,
                       last_item_o);
          end
        end
      end
      if (hold_req && out_valid_o) begin
        hold_req = 0;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready_i <= 0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
        if (idle_on && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else quiet++;
    if (quiet >= WATCH_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
      $display("** dag_task_completion_times: FAILED **");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] op, int a, int b, int d);
    pending_cmds.push_back('{op: op, src: a[5:0], dst: b[5:0], dur: d[15:0]});
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid_i || due_orders.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_count(int v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v[6:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    task_cnt = v[6:0];
  endtask

  task automatic random_phase(int cnt, int len);
    int unsigned n, a, b, t;
    set_count(cnt);
    n = live_tasks();
    if ($urandom_range(0, 2) == 0) push_cmd(dtct_pkg::OP_CLEAR, $urandom_range(0, 63), 0, 0);
    repeat (len) begin
      case ($urandom_range(0, 11))
        0, 1, 2: push_cmd(dtct_pkg::OP_SETD, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 65535));
        3: push_cmd(dtct_pkg::OP_ADDE, $urandom_range(0, 63), $urandom_range(0, 63), 0);
        default: begin
          a = $urandom_range(0, n - 1);
          b = $urandom_range(0, n - 1);
          if (a > b) begin
            t = a;
            a = b;
            b = t;
          end
          if (a != b) push_cmd(dtct_pkg::OP_ADDE, a, b, $urandom_range(0, 65535));
          else push_cmd(dtct_pkg::OP_SETD, a, 0, $urandom_range(0, 65535));
        end
      endcase
    end
    push_cmd(dtct_pkg::OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
             $urandom_range(0, 65535));
  endtask

  initial begin
    int cnt;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 7'd64;
    idle_on = 1;
    hold_req = 0;
    errors = 0;
    quiet = 0;
    foreach (dur_tbl[i]) dur_tbl[i] = 0;
    foreach (head_tbl[i]) head_tbl[i] = NE;
    edge_cnt = 0;
    drop_seen = 0;
    task_cnt = NV;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset graph, extremes, self edge, bad edges, count limits
    push_cmd(dtct_pkg::OP_RUN, 0, 0, 0);
    push_cmd(dtct_pkg::OP_SETD, 63, 0, 65535);
    push_cmd(dtct_pkg::OP_SETD, 0, 63, 65535);
    push_cmd(dtct_pkg::OP_ADDE, 0, 1, 0);
    push_cmd(dtct_pkg::OP_ADDE, 1, 63, 0);
    push_cmd(dtct_pkg::OP_ADDE, 0, 63, 0);
    hold_req = 1;
    push_cmd(dtct_pkg::OP_RUN, 63, 63, 65535);
    push_cmd(dtct_pkg::OP_SETD, 5, 0, 16'h00ff);
    push_cmd(dtct_pkg::OP_SETD, 42, 21, 16'hff00);
    push_cmd(dtct_pkg::OP_RUN, 21, 42, 16'h5555);
    set_count(5);
    push_cmd(dtct_pkg::OP_ADDE, 7, 1, 0);
    push_cmd(dtct_pkg::OP_ADDE, 1, 6, 0);
    push_cmd(dtct_pkg::OP_ADDE, 2, 2, 0);
    push_cmd(dtct_pkg::OP_RUN, 0, 0, 0);
    push_cmd(dtct_pkg::OP_CLEAR, 0, 0, 0);
    push_cmd(dtct_pkg::OP_RUN, 0, 0, 0);
    set_count(0);
    push_cmd(dtct_pkg::OP_RUN, 0, 0, 0);
    set_count(127);
    push_cmd(dtct_pkg::OP_ADDE, 10, 3, 0);
    push_cmd(dtct_pkg::OP_ADDE, 3, 40, 0);
    push_cmd(dtct_pkg::OP_ADDE, 40, 1, 0);
    set_count(20);
    push_cmd(dtct_pkg::OP_RUN, 0, 0, 0);

    // Fill the edge store past capacity with a forward-only graph
    set_count(64);
    push_cmd(dtct_pkg::OP_CLEAR, 0, 0, 0);
    repeat (262) begin
      int a, b;
      a = $urandom_range(0, 62);
      b = $urandom_range(a + 1, 63);
      push_cmd(dtct_pkg::OP_ADDE, a, b, $urandom_range(0, 65535));
    end
    push_cmd(dtct_pkg::OP_RUN, 0, 0, 0);

    for (int p = 0; p < 14; p++) begin
      if (p == 11) idle_on = 0;
      case ($urandom_range(0, 7))
        0: cnt = 64;
        1: cnt = $urandom_range(65, 127);
        2: cnt = $urandom_range(0, 1);
        default: cnt = $urandom_range(2, 12);
      endcase
      random_phase(cnt, $urandom_range(4, 10));
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d commands, %0d runs (%0d with a cycle), %0d result items",
             cmds_sent, runs_done, cycles_seen, orders_seen);
    if (errors == 0 && due_orders.size() == 0) begin
      $display("** dag_task_completion_times: PASSED **");
    end else begin
      $display("%0d mismatches, %0d items still due", errors, due_orders.size());
      $display("** dag_task_completion_times: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dtct_pkg.sv
rtl/core/dtct_ram.sv
rtl/core/dag_task_completion_times.sv
test/dag_task_completion_times_test.sv
